>>> rtl/gkxlit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkxlit_pkg
// Shared constants, types and letter tables for the Greek transliterator.
// ----------------------------------------------------------------------------
package gkxlit_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LETTER_W = 7;
    localparam int unsigned SKIP_W   = 2;

    // Lead bytes of the Greek block and the three-byte punctuation lead.
    localparam logic [BYTE_W-1:0] LEAD_CE     = 8'hCE;
    localparam logic [BYTE_W-1:0] LEAD_CF     = 8'hCF;
    localparam logic [BYTE_W-1:0] LEAD_MARK3  = 8'hE2;

    // Follower ranges used by case folding and mapping.
    localparam logic [BYTE_W-1:0] CE_ALPHA    = 8'hB1;
    localparam logic [BYTE_W-1:0] CE_OMICRON  = 8'hBF;
    localparam logic [BYTE_W-1:0] CAP_LO      = 8'hA0;
    localparam logic [BYTE_W-1:0] CAP_HI      = 8'hA9;
    localparam logic [BYTE_W-1:0] CF_PI       = 8'h80;
    localparam logic [BYTE_W-1:0] CF_OMEGA    = 8'h89;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

    // Single-byte tokens.
    localparam logic [BYTE_W-1:0] BYTE_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] BYTE_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] BYTE_LATIN_C = 8'h63;

    localparam logic [LETTER_W-1:0] LETTER_S  = 7'h73;
    localparam logic [LETTER_W-1:0] LETTER_A  = 7'h61;
    localparam logic [LETTER_W-1:0] LETTER_Y  = 7'h79;

    localparam logic [SKIP_W-1:0] MARK3_SKIP  = 2'd2;

    // Result of mapping one lead/follower pair.
    typedef struct packed {
        logic                hit;
        logic [LETTER_W-1:0] letter;
    } pair_map_t;

    function automatic logic is_blank(input logic [BYTE_W-1:0] b);
        return (b == BYTE_SPACE) || ((b >= BYTE_TAB) && (b <= BYTE_CR));
    endfunction

    // Letters for CE B1..BF, indexed by follower minus B1.
    function automatic logic [LETTER_W-1:0] ce_letter(input logic [3:0] idx);
        logic [LETTER_W-1:0] l;
        case (idx)
            4'd0:    l = 7'h61; // a
            4'd1:    l = 7'h62; // b
            4'd2:    l = 7'h67; // g
            4'd3:    l = 7'h64; // d
            4'd4:    l = 7'h65; // e
            4'd5:    l = 7'h71; // q
            4'd6:    l = 7'h68; // h
            4'd7:    l = 7'h75; // u
            4'd8:    l = 7'h69; // i
            4'd9:    l = 7'h6B; // k
            4'd10:   l = 7'h6C; // l
            4'd11:   l = 7'h6D; // m
            4'd12:   l = 7'h6E; // n
            4'd13:   l = 7'h6A; // j
            4'd14:   l = 7'h6F; // o
            default: l = 7'h6F;
        endcase
        return l;
    endfunction

    // Letters for CF 80..89, indexed by follower minus 80.
    function automatic logic [LETTER_W-1:0] cf_letter(input logic [3:0] idx);
        logic [LETTER_W-1:0] l;
        case (idx)
            4'd0:    l = 7'h70; // p
            4'd1:    l = 7'h72; // r
            4'd2:    l = 7'h73; // s (final sigma)
            4'd3:    l = 7'h73; // s
            4'd4:    l = 7'h74; // t
            4'd5:    l = 7'h79; // y
            4'd6:    l = 7'h66; // f
            4'd7:    l = 7'h78; // x
            4'd8:    l = 7'h63; // c
            4'd9:    l = 7'h76; // v
            default: l = 7'h76;
        endcase
        return l;
    endfunction

endpackage

>>> rtl/greek_utf8_transliterator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greek_utf8_transliterator
// Turns a UTF-8 byte stream of Greek text into Latin lower-case letters.
// ----------------------------------------------------------------------------
// Path: the final byte of a letter passes the input register, then the result
// register, from which the letter is presented on the result port.
// Throughput: one byte per cycle while the result side keeps taking words; a
// held result stalls the byte in the input register and then drops s_ready.
// Reset: synchronous active-low aresetn empties both registers and clears the
// held lead byte and the skip count.
// ----------------------------------------------------------------------------
module greek_utf8_transliterator (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_latin_letter
);
    import gkxlit_pkg::*;

    // Input register stage.
    logic                in_valid_reg,  in_valid_next;
    logic [BYTE_W-1:0]   in_byte_reg,   in_byte_next;

    // Word state: a pending lead byte and the count of bytes still to drop.
    logic                held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0]   held_lead_reg,  held_lead_next;
    logic [SKIP_W-1:0]   skip_count_reg, skip_count_next;

    // Result register stage.
    logic                out_valid_reg,  out_valid_next;
    logic [LETTER_W-1:0] out_letter_reg, out_letter_next;

    logic                out_free;
    logic                proceed;
    logic                emit;
    logic [LETTER_W-1:0] emit_letter;
    pair_map_t           pair_map;

    // The result register can take a new word when it is empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    // The byte in the input register is processed when the result side has room.
    assign proceed  = in_valid_reg && out_free;
    // The input register accepts whenever its current byte moves on or it is empty.
    assign s_ready  = !in_valid_reg || out_free;

    assign m_valid        = out_valid_reg;
    assign m_latin_letter = out_letter_reg;

    gkxlit_pair_map u_pair_map (
        .lead_byte   (held_lead_reg),
        .follow_byte (in_byte_reg),
        .map_out     (pair_map)
    );

    // Input stage next values.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_byte_next  = s_text_byte;
        end
    end

    // Word state update. Whitespace wins over everything, then skipping,
    // then completion of a held pair, then the single-byte tokens.
    always_comb begin
        held_valid_next = held_valid_reg;
        held_lead_next  = held_lead_reg;
        skip_count_next = skip_count_reg;
        emit            = 1'b0;
        emit_letter     = pair_map.letter;
        if (proceed) begin
            if (is_blank(in_byte_reg)) begin
                held_valid_next = 1'b0;
                held_lead_next  = '0;
                skip_count_next = '0;
            end else if (skip_count_reg != '0) begin
                skip_count_next = skip_count_reg - 1'b1;
            end else if (held_valid_reg) begin
                // The pair is complete; the mapper reports a miss for any lead
                // other than CE or CF, so such pairs are simply dropped.
                held_valid_next = 1'b0;
                held_lead_next  = '0;
                emit            = pair_map.hit;
            end else if ((in_byte_reg == BYTE_CONT) || (in_byte_reg == BYTE_LPAREN)
                    || (in_byte_reg == BYTE_RPAREN)) begin
                // Stray continuation byte and parentheses are consumed alone.
            end else if (in_byte_reg == BYTE_LATIN_C) begin
                emit        = 1'b1;
                emit_letter = LETTER_S;
            end else if (in_byte_reg == LEAD_MARK3) begin
                skip_count_next = MARK3_SKIP;
            end else begin
                held_valid_next = 1'b1;
                held_lead_next  = in_byte_reg;
            end
        end
    end

    // Result stage next values.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_letter_next = out_letter_reg;
        if (out_free) begin
            out_valid_next = proceed && emit;
            if (emit) begin
                out_letter_next = emit_letter;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            held_lead_reg  <= '0;
            skip_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            held_valid_reg <= held_valid_next;
            held_lead_reg  <= held_lead_next;
            skip_count_reg <= skip_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        in_byte_reg    <= in_byte_next;
        out_letter_reg <= out_letter_next;
    end

    // A lead byte is never held while bytes of a three-byte mark are dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (skip_count_reg != '0) |-> !held_valid_reg)
        else $error("lead byte held during skip");

    // Any letter presented is in the lower-case range of the tables.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_latin_letter >= LETTER_A) && (m_latin_letter <= LETTER_Y)))
        else $error("result letter out of range");

    // Whitespace leaves the word state cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && is_blank(in_byte_reg)) |=>
            (!held_valid_reg && (skip_count_reg == '0)))
        else $error("word state not cleared by whitespace");

    // A processed byte that emits nothing leaves no result behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && !emit) |=> !m_valid)
        else $error("result appeared without a letter");

endmodule

>>> rtl/gkxlit_pair_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkxlit_pair_map
// Folds a two-byte Greek character to lower case and maps it to one letter.
// ----------------------------------------------------------------------------
module gkxlit_pair_map (
    input  logic [7:0]              lead_byte,
    input  logic [7:0]              follow_byte,
    output gkxlit_pkg::pair_map_t   map_out
);
    import gkxlit_pkg::*;

    logic [BYTE_W-1:0] follow_a;
    logic [BYTE_W-1:0] follow_b;
    logic [BYTE_W-1:0] follow_c;
    logic [BYTE_W-1:0] lead_b;
    logic [3:0]        ce_off;
    logic [3:0]        cf_off;

    always_comb begin
        // Capitals below alpha move up into the small-letter range.
        follow_a = follow_byte;
        if ((lead_byte == LEAD_CE) && (follow_byte < CE_ALPHA)
                && !((follow_byte >= CAP_LO) && (follow_byte <= CAP_HI))) begin
            follow_a = follow_byte + CASE_OFFSET;
        end

        // Capitals pi..omega live in CE but their small forms live in CF.
        lead_b   = lead_byte;
        follow_b = follow_a;
        if ((lead_byte == LEAD_CE) && (follow_a >= CAP_LO) && (follow_a <= CAP_HI)) begin
            lead_b   = LEAD_CF;
            follow_b = follow_a - CASE_OFFSET;
        end

        follow_c = follow_b;
        if ((lead_b == LEAD_CF) && (follow_b < CF_PI)) begin
            follow_c = follow_b + CASE_OFFSET;
        end

        ce_off = 4'(follow_c - CE_ALPHA);
        cf_off = 4'(follow_c - CF_PI);

        map_out = '0;
        if ((lead_b == LEAD_CE) && (follow_c >= CE_ALPHA) && (follow_c <= CE_OMICRON)) begin
            map_out.hit    = 1'b1;
            map_out.letter = ce_letter(ce_off);
        end else if ((lead_b == LEAD_CF) && (follow_c >= CF_PI)
                && (follow_c <= CF_OMEGA)) begin
            map_out.hit    = 1'b1;
            map_out.letter = cf_letter(cf_off);
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Greek UTF-8 to Latin transliterator.
// ----------------------------------------------------------------------------
// A fixed table of directed bytes runs first. Rows whose letter is obvious
// carry it inline; the rest go through the in-bench letter predictor. After
// that come random runs of text, mostly well-formed Greek pairs with random
// content, plus marks, parentheses, broken pairs and raw noise. Both sides
// idle at random. The result side also holds off once for a long stretch,
// and the byte side pauses now and then until every letter has drained.
// ----------------------------------------------------------------------------
module tb_top;

    import gkxlit_pkg::*;

    localparam int unsigned CLK_HALF_NS  = 5;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned RANDOM_BYTES = 1600;
    // The limit covers the slowest legal run several times over, plus the long
    // hold-off and the drain pauses.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned HOLD_AFTER   = 150;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PRINT_CAP    = 40;

    // How a stimulus row is checked. A drain row carries no byte: the sender
    // stops and waits until every expected letter has come out.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_LETTER,
        ROW_QUIET,
        ROW_DRAIN
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [BYTE_W-1:0]   text_byte;
        logic [LETTER_W-1:0] letter;
    } stim_t;

    // Lower-case letter rows, leftmost character first.
    localparam logic [15*8-1:0] CE_ROW = "abgdeqhuiklmnjo";
    localparam logic [10*8-1:0] CF_ROW = "prsstyfxcv";

    // Directed table. Only the plainly visible outcomes are typed in; a
    // quiet row means the byte must not produce a letter.
    localparam stim_t DIRECTED_ROWS [25] = '{
        '{ROW_LETTER,  BYTE_LATIN_C, LETTER_S},  // latin c straight after reset
        '{ROW_QUIET,   LEAD_CE,      7'd0},
        '{ROW_LETTER,  CE_ALPHA,     LETTER_A},  // first entry of the CE row
        '{ROW_QUIET,   LEAD_CF,      7'd0},
        '{ROW_LETTER,  CF_OMEGA,     7'h76},     // last entry of the CF row, 'v'
        '{ROW_QUIET,   LEAD_CE,      7'd0},
        '{ROW_PREDICT, 8'h91,        7'd0},      // capital alpha folds up
        '{ROW_QUIET,   LEAD_CE,      7'd0},
        '{ROW_PREDICT, CAP_HI,       7'd0},      // capital omega moves to CF
        '{ROW_QUIET,   LEAD_CF,      7'd0},
        '{ROW_PREDICT, 8'h62,        7'd0},      // CF follower below 0x80
        '{ROW_QUIET,   LEAD_MARK3,   7'd0},      // three-byte mark drops itself
        '{ROW_QUIET,   8'h80,        7'd0},      // ...and the next two bytes
        '{ROW_QUIET,   8'h94,        7'd0},
        '{ROW_LETTER,  BYTE_LATIN_C, LETTER_S},
        '{ROW_QUIET,   BYTE_LPAREN,  7'd0},
        '{ROW_QUIET,   BYTE_RPAREN,  7'd0},
        '{ROW_QUIET,   BYTE_CONT,    7'd0},
        '{ROW_QUIET,   LEAD_CE,      7'd0},
        '{ROW_QUIET,   BYTE_SPACE,   7'd0},      // space drops the held lead
        '{ROW_PREDICT, 8'hFF,        7'd0},
        '{ROW_PREDICT, 8'h00,        7'd0},      // non-Greek pair is dropped
        '{ROW_QUIET,   BYTE_TAB,     7'd0},
        '{ROW_QUIET,   LEAD_CE,      7'd0},
        '{ROW_QUIET,   BYTE_CR,      7'd0}
    };

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_text_byte    = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [LETTER_W-1:0] m_latin_letter;

    // Predictor state: the run-of-text state as the block should hold it.
    logic                lead_held = 1'b0;
    logic [BYTE_W-1:0]   lead_byte = '0;
    logic [SKIP_W-1:0]   mark_skip = '0;

    stim_t               stim_q[$];
    logic [LETTER_W-1:0] pending_letters[$];

    int unsigned cycle_count  = 0;
    int unsigned mismatches   = 0;
    int unsigned letters_seen = 0;
    bit          rx_hold      = 1'b0;

    greek_utf8_transliterator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_latin_letter (m_latin_letter)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Letter predictor
    // ------------------------------------------------------------------------

    // Fold a CE/CF pair to lower case and look the letter up. Capitals in
    // CE 91..9F move up by 0x20, capitals in CE A0..A9 move over to CF 80..89,
    // and CF followers below 0x80 move up by 0x20. Anything left outside the
    // two lower-case ranges is not a letter.
    function automatic pair_map_t fold_greek_pair(logic [BYTE_W-1:0] lead,
                                                  logic [BYTE_W-1:0] follow);
        pair_map_t   found;
        logic [BYTE_W-1:0] idx;
        found = '0;
        if (lead == LEAD_CE && follow < CE_ALPHA && !(follow >= CAP_LO && follow <= CAP_HI))
            follow = follow + CASE_OFFSET;
        if (lead == LEAD_CE && follow >= CAP_LO && follow <= CAP_HI) begin
            lead   = LEAD_CF;
            follow = follow - CASE_OFFSET;
        end
        if (lead == LEAD_CF && follow < CF_PI)
            follow = follow + CASE_OFFSET;
        if (lead == LEAD_CE && follow >= CE_ALPHA && follow <= CE_OMICRON) begin
            idx          = follow - CE_ALPHA;
            found.hit    = 1'b1;
            found.letter = CE_ROW[(14 - idx) * 8 +: LETTER_W];
        end else if (lead == LEAD_CF && follow >= CF_PI && follow <= CF_OMEGA) begin
            idx          = follow - CF_PI;
            found.hit    = 1'b1;
            found.letter = CF_ROW[(9 - idx) * 8 +: LETTER_W];
        end
        return found;
    endfunction

    // Advance the predicted state by one byte and return the letter it
    // causes, if any.
    function automatic pair_map_t transliterate_byte(logic [BYTE_W-1:0] b);
        pair_map_t found;
        found = '0;
        if (b == BYTE_SPACE || (b >= BYTE_TAB && b <= BYTE_CR)) begin
            // Whitespace ends the run of text and forgets everything.
            lead_held = 1'b0;
            lead_byte = '0;
            mark_skip = '0;
        end else if (mark_skip != 0) begin
            mark_skip = mark_skip - 1'b1;
        end else if (lead_held) begin
            lead_held = 1'b0;
            if (lead_byte == LEAD_CE || lead_byte == LEAD_CF)
                found = fold_greek_pair(lead_byte, b);
            lead_byte = '0;
        end else if (b == BYTE_CONT || b == BYTE_LPAREN || b == BYTE_RPAREN) begin
            // Consumed on its own, nothing comes out.
        end else if (b == BYTE_LATIN_C) begin
            found.hit    = 1'b1;
            found.letter = LETTER_S;
        end else if (b == LEAD_MARK3) begin
            mark_skip = MARK3_SKIP;
        end else begin
            lead_held = 1'b1;
            lead_byte = b;
        end
        return found;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------

    // Append one row at the tail of the stimulus queue.
    task automatic queue_row(input stim_t row);
        stim_q.insert(stim_q.size(), row);
    endtask

    // Append one letter at the tail of the expected queue.
    task automatic expect_letter(input logic [LETTER_W-1:0] l);
        pending_letters.insert(pending_letters.size(), l);
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] b);
        queue_row('{kind: ROW_PREDICT, text_byte: b, letter: '0});
    endtask

    task automatic add_blank();
        int unsigned pick;
        pick = $urandom_range(0, 5);
        add_byte(pick == 5 ? BYTE_SPACE : BYTE_TAB + 8'(pick));
    endtask

    // One run of text between blanks. Most runs are well-formed Greek with
    // random letters; a few are raw noise, and some are left unterminated so
    // that the next run starts in the middle of a pair or a mark.
    task automatic add_random_run();
        int unsigned tokens;
        int unsigned pick;
        tokens = $urandom_range(1, 8);
        if ($urandom_range(0, 99) < 12) begin
            repeat (tokens * 2) add_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat (tokens) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    if ($urandom_range(0, 2) != 0) begin
                        add_byte(LEAD_CE);
                        add_byte(8'($urandom_range(CE_ALPHA, CE_OMICRON)));
                    end else begin
                        add_byte(LEAD_CF);
                        add_byte(8'($urandom_range(CF_PI, CF_OMEGA)));
                    end
                end else if (pick < 70) begin
                    // Capitals, including the unassigned hole at CE A2.
                    add_byte(LEAD_CE);
                    add_byte(8'($urandom_range(8'h91, CAP_HI)));
                end else if (pick < 75) begin
                    add_byte(LEAD_CF);
                    add_byte(8'($urandom_range(0, 8'h7F)));
                end else if (pick < 80) begin
                    add_byte(BYTE_LATIN_C);
                end else if (pick < 85) begin
                    add_byte(LEAD_MARK3);
                    add_byte(8'($urandom_range(8'h80, 8'hBF)));
                    add_byte(8'($urandom_range(8'h80, 8'hBF)));
                end else if (pick < 90) begin
                    case ($urandom_range(0, 2))
                        0:       add_byte(BYTE_LPAREN);
                        1:       add_byte(BYTE_RPAREN);
                        default: add_byte(BYTE_CONT);
                    endcase
                end else if (pick < 95) begin
                    add_byte($urandom_range(0, 1) != 0 ? LEAD_CE : LEAD_CF);
                    add_byte(8'($urandom_range(0, 255)));
                end else begin
                    add_byte(8'($urandom_range(0, 255)));
                    add_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        if ($urandom_range(0, 9) != 0)
            add_blank();
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Result side: every accepted letter is compared with the oldest one
    // expected. m_ready is redrawn at each edge: a random stall after each word,
    // no stall in burst stretches, and a forced hold-off while rx_hold is set.
    initial begin
        int unsigned         rx_wait;
        bit                  rx_burst;
        logic [LETTER_W-1:0] want;
        rx_wait  = 0;
        rx_burst = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                letters_seen++;
                if (pending_letters.size() == 0) begin
                    report_mismatch($sformatf("letter 0x%02h with none expected",
                                              m_latin_letter));
                end else begin
                    want = pending_letters.pop_front();
                    if (m_latin_letter !== want)
                        report_mismatch($sformatf("latin_letter 0x%02h, expected 0x%02h",
                                                  m_latin_letter, want));
                end
                if ($urandom_range(0, 49) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 5);
            end
            if (rx_hold) begin
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Long hold-off on the result side, timed here in its own process. The
    // sender keeps offering bytes meanwhile, so the block fills and has to
    // drop s_ready.
    initial begin
        wait (letters_seen >= HOLD_AFTER);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // Watchdog.
    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte side: reset, then every row in order, predicting at acceptance.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned gap;
        bit          tx_burst;
        stim_t       row;
        pair_map_t   predicted;
        tx_burst = 1'b0;

        foreach (DIRECTED_ROWS[i])
            queue_row(DIRECTED_ROWS[i]);
        // Let the directed part drain completely before the random part.
        queue_row('{kind: ROW_DRAIN, text_byte: '0, letter: '0});
        while (stim_q.size() < RANDOM_BYTES + $size(DIRECTED_ROWS)) begin
            add_random_run();
            if ($urandom_range(0, 39) == 0)
                queue_row('{kind: ROW_DRAIN, text_byte: '0, letter: '0});
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        while (stim_q.size() != 0) begin
            row = stim_q.pop_front();
            if (row.kind == ROW_DRAIN) begin
                // Step one edge first so s_valid is not lowered and raised
                // again within the same time step.
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_letters.size() != 0) @(posedge aclk);
                continue;
            end
            if ($urandom_range(0, 59) == 0)
                tx_burst = !tx_burst;
            gap = tx_burst ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid     <= 1'b1;
            s_text_byte <= row.text_byte;
            do @(posedge aclk); while (!s_ready);

            // The word was taken at this edge; the predictor always runs so
            // its state follows the block, but typed rows set the outcome.
            predicted = transliterate_byte(row.text_byte);
            case (row.kind)
                ROW_LETTER: expect_letter(row.letter);
                ROW_QUIET:  ;
                default:    if (predicted.hit) expect_letter(predicted.letter);
            endcase
        end
        s_valid <= 1'b0;

        // Let the last letters out, then keep watching for strays.
        while (pending_letters.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/gkxlit_pkg.sv
rtl/gkxlit_pair_map.sv
rtl/greek_utf8_transliterator.sv
sim/tb_top.sv
